// ===== src/mqtt_packet_parser_assert.svh =====
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MQTT_PACKET_PARSER_ASSERT_SVH
`define MQTT_PACKET_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mpp_pkg.sv =====
// ----------------------------------------------------------------------------
// MQTT packet parser package
// Shared types, codes and constants of the parser front, queue and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpp_pkg;

    localparam int DATA_W        = 8;
    localparam int LEN_W         = 28;
    localparam int TOPIC_W       = 16;
    localparam int PID_W         = 16;
    localparam int ROLE_W        = 4;
    localparam int ERR_W         = 3;
    localparam int NIB_W         = 4;
    localparam int OUT_TDATA_W   = 112;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TOPIC_W-1:0] MAX_TOPIC_RESET = 16'd256;
    localparam logic [TOPIC_W-1:0] MIN_TOPIC_LIMIT = 16'd2;

    typedef enum logic [9:0] {
        PH_HDR     = 10'b00_0000_0001,
        PH_LEN     = 10'b00_0000_0010,
        PH_TLEN_HI = 10'b00_0000_0100,
        PH_TLEN_LO = 10'b00_0000_1000,
        PH_TOPIC   = 10'b00_0001_0000,
        PH_PID_HI  = 10'b00_0010_0000,
        PH_PID_LO  = 10'b00_0100_0000,
        PH_CONN    = 10'b00_1000_0000,
        PH_REST    = 10'b01_0000_0000,
        PH_DISCARD = 10'b10_0000_0000
    } phase_t;

    localparam logic [ROLE_W-1:0] ROLE_HEADER    = 4'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH    = 4'd1;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC_LEN = 4'd2;
    localparam logic [ROLE_W-1:0] ROLE_TOPIC     = 4'd3;
    localparam logic [ROLE_W-1:0] ROLE_PACKET_ID = 4'd4;
    localparam logic [ROLE_W-1:0] ROLE_CONNACK   = 4'd5;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD   = 4'd6;
    localparam logic [ROLE_W-1:0] ROLE_DISCARD   = 4'd7;
    localparam logic [ROLE_W-1:0] ROLE_EXTRA     = 4'd8;

    localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_QOS3      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LEN_LONG  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNC     = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TOPIC     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_PINGRESP  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 3'd6;
    localparam logic [ERR_W-1:0] ERR_MALFORMED = 3'd7;

    localparam logic [NIB_W-1:0] CMD_CONNACK  = 4'd2;
    localparam logic [NIB_W-1:0] CMD_PUBLISH  = 4'd3;
    localparam logic [NIB_W-1:0] CMD_PUBACK   = 4'd4;
    localparam logic [NIB_W-1:0] CMD_PUBREC   = 4'd5;
    localparam logic [NIB_W-1:0] CMD_PUBREL   = 4'd6;
    localparam logic [NIB_W-1:0] CMD_PUBCOMP  = 4'd7;
    localparam logic [NIB_W-1:0] CMD_SUBACK   = 4'd9;
    localparam logic [NIB_W-1:0] CMD_UNSUBACK = 4'd11;
    localparam logic [NIB_W-1:0] CMD_PINGRESP = 4'd13;

    localparam logic [1:0] QOS_INVALID = 2'b11;

    typedef struct packed {
        logic [ROLE_W-1:0]  role;
        logic [DATA_W-1:0]  value;
        logic               done;
        logic [NIB_W-1:0]   cmd;
        logic [NIB_W-1:0]   flags;
        logic [LEN_W-1:0]   rem_len;
        logic [TOPIC_W-1:0] topic_len;
        logic [PID_W-1:0]   packet_id;
        logic [ERR_W-1:0]   err;
    } item_t;

endpackage

`default_nettype wire

// ===== src/mpp_front.sv =====
// ----------------------------------------------------------------------------
// MQTT packet parser front
// Parses one byte per cycle while the queue is not full, assigns its role and
// produces a classified item with the packet summary fields on the closing byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpp_front #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mpp_pkg::DATA_W-1:0]  in_byte,
    input  wire logic                        in_end,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [mpp_pkg::TOPIC_W-1:0] cfg_data,
    input  wire logic                        q_full,
    output logic                             push,
    output mpp_pkg::item_t                   push_item
);

    import mpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    phase_t             phase_reg,     phase_next;
    logic [NIB_W-1:0]   cmd_reg,       cmd_next;
    logic [NIB_W-1:0]   flags_reg,     flags_next;
    logic [LEN_W-1:0]   len_reg,       len_next;
    logic [CNT_W-1:0]   cnt_reg,       cnt_next;
    logic [LEN_W-1:0]   left_reg,      left_next;
    logic [TOPIC_W-1:0] tlen_reg,      tlen_next;
    logic [TOPIC_W-1:0] tleft_reg,     tleft_next;
    logic [PID_W-1:0]   pid_reg,       pid_next;
    logic [TOPIC_W-1:0] max_topic_reg;

    logic [LEN_W-1:0]   left_dec;
    logic [LEN_W-1:0]   len_grp;
    logic [LEN_W-1:0]   len_acc;
    logic [17:0]        need;
    logic [TOPIC_W-1:0] tlen_full;
    logic [TOPIC_W-1:0] tleft_dec;
    logic [1:0]         grp_idx;
    logic               qos_nz;
    logic               body_step;
    logic               err_end;
    logic [ERR_W-1:0]   err_code;
    phase_t             body_target;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign push      = in_valid && !q_full;

    assign left_dec  = (left_reg != '0) ? left_reg - LEN_W'(1) : '0;
    assign tleft_dec = (tleft_reg != '0) ? tleft_reg - TOPIC_W'(1) : '0;
    assign qos_nz    = (flags_reg[2:1] != 2'b00);
    assign grp_idx   = 2'(cnt_reg);
    assign tlen_full = {tlen_reg[15:8], in_byte};
    assign need      = 18'd2 + 18'(tlen_full) + (qos_nz ? 18'd2 : 18'd0);

    always_comb
    begin
        case (grp_idx)
            2'd0:    len_grp = {21'd0, in_byte[6:0]};
            2'd1:    len_grp = {14'd0, in_byte[6:0], 7'd0};
            2'd2:    len_grp = {7'd0, in_byte[6:0], 14'd0};
            default: len_grp = {in_byte[6:0], 21'd0};
        endcase
        len_acc = len_reg | len_grp;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        tlen_next   = tlen_reg;
        tleft_next  = tleft_reg;
        pid_next    = pid_reg;
        push_item   = '0;
        body_step   = 1'b0;
        body_target = phase_reg;
        err_end     = 1'b0;
        err_code    = ERR_OK;

        push_item.value = in_byte;
        push_item.role  = ROLE_HEADER;

        case (phase_reg)
            PH_HDR:
            begin
                cmd_next   = in_byte[7:4];
                flags_next = in_byte[3:0];
                len_next   = '0;
                cnt_next   = '0;
                left_next  = '0;
                tlen_next  = '0;
                tleft_next = '0;
                pid_next   = '0;
                if (max_topic_reg < MIN_TOPIC_LIMIT)
                begin
                    err_end  = 1'b1;
                    err_code = ERR_MALFORMED;
                end
                else if (in_byte[2:1] == QOS_INVALID)
                begin
                    err_end  = 1'b1;
                    err_code = ERR_QOS3;
                end
                else if (in_end)
                begin
                    err_end  = 1'b1;
                    err_code = ERR_TRUNC;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                push_item.role = ROLE_LENGTH;
                len_next       = len_acc;
                cnt_next       = cnt_reg + CNT_W'(1);
                if (in_byte[7])
                begin
                    if (cnt_next >= CNT_W'(MAX_LENGTH_BYTES))
                    begin
                        err_end  = 1'b1;
                        err_code = ERR_LEN_LONG;
                    end
                    else if (in_end)
                    begin
                        err_end  = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                end
                else
                begin
                    left_next = len_acc;
                    case (cmd_reg)
                        CMD_PUBLISH:
                            body_target = PH_TLEN_HI;
                        CMD_CONNACK:
                            body_target = PH_CONN;
                        CMD_PUBACK, CMD_PUBREC, CMD_PUBREL, CMD_PUBCOMP, CMD_SUBACK,
                        CMD_UNSUBACK:
                            body_target = PH_PID_HI;
                        default:
                            body_target = PH_HDR;
                    endcase
                    if (cmd_reg == CMD_PINGRESP)
                    begin
                        if (len_acc != '0)
                        begin
                            err_end  = 1'b1;
                            err_code = ERR_PINGRESP;
                        end
                        else
                        begin
                            push_item.done = 1'b1;
                            phase_next     = PH_HDR;
                        end
                    end
                    else if (body_target == PH_HDR)
                    begin
                        err_end  = 1'b1;
                        err_code = ERR_UNKNOWN;
                    end
                    else if (len_acc < LEN_W'(2))
                    begin
                        err_end  = 1'b1;
                        err_code = ERR_MALFORMED;
                    end
                    else if (in_end)
                    begin
                        err_end  = 1'b1;
                        err_code = ERR_TRUNC;
                    end
                    else
                    begin
                        phase_next = body_target;
                    end
                end
            end
            PH_TLEN_HI:
            begin
                push_item.role = ROLE_TOPIC_LEN;
                tlen_next      = {in_byte, 8'd0};
                body_step      = 1'b1;
                body_target    = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                push_item.role = ROLE_TOPIC_LEN;
                tlen_next      = tlen_full;
                if (tlen_full > max_topic_reg)
                begin
                    err_end  = 1'b1;
                    err_code = ERR_TOPIC;
                end
                else if (LEN_W'(need) > len_reg)
                begin
                    err_end  = 1'b1;
                    err_code = ERR_MALFORMED;
                end
                else
                begin
                    tleft_next = tlen_full;
                    body_step  = 1'b1;
                    if (tlen_full != '0)
                    begin
                        body_target = PH_TOPIC;
                    end
                    else
                    begin
                        body_target = qos_nz ? PH_PID_HI : PH_REST;
                    end
                end
            end
            PH_TOPIC:
            begin
                push_item.role = ROLE_TOPIC;
                tleft_next     = tleft_dec;
                body_step      = 1'b1;
                if (tleft_dec != '0)
                begin
                    body_target = PH_TOPIC;
                end
                else
                begin
                    body_target = qos_nz ? PH_PID_HI : PH_REST;
                end
            end
            PH_PID_HI:
            begin
                push_item.role = ROLE_PACKET_ID;
                pid_next       = {in_byte, 8'd0};
                body_step      = 1'b1;
                body_target    = PH_PID_LO;
            end
            PH_PID_LO:
            begin
                push_item.role = ROLE_PACKET_ID;
                pid_next       = {pid_reg[15:8], in_byte};
                body_step      = 1'b1;
                body_target    = PH_REST;
            end
            PH_CONN:
            begin
                push_item.role = ROLE_CONNACK;
                body_step      = 1'b1;
                body_target    = (len_reg != left_reg) ? PH_REST : PH_CONN;
            end
            PH_REST:
            begin
                if (cmd_reg == CMD_PUBLISH || cmd_reg == CMD_SUBACK)
                begin
                    push_item.role = ROLE_PAYLOAD;
                end
                else
                begin
                    push_item.role = ROLE_EXTRA;
                end
                body_step   = 1'b1;
                body_target = PH_REST;
            end
            default:
            begin
                push_item.role = ROLE_DISCARD;
                phase_next     = in_end ? PH_HDR : PH_DISCARD;
            end
        endcase

        if (body_step)
        begin
            left_next = left_dec;
            if (left_dec == '0)
            begin
                push_item.done = 1'b1;
                phase_next     = PH_HDR;
            end
            else if (in_end)
            begin
                err_end  = 1'b1;
                err_code = ERR_TRUNC;
            end
            else
            begin
                phase_next = body_target;
            end
        end

        if (err_end)
        begin
            push_item.done = 1'b1;
            push_item.err  = err_code;
            phase_next     = in_end ? PH_HDR : PH_DISCARD;
        end

        push_item.cmd       = cmd_next;
        push_item.flags     = flags_next;
        push_item.rem_len   = len_next;
        push_item.topic_len = tlen_next;
        push_item.packet_id = pid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            cmd_reg       <= '0;
            flags_reg     <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            tlen_reg      <= '0;
            tleft_reg     <= '0;
            pid_reg       <= '0;
            max_topic_reg <= MAX_TOPIC_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_topic_reg <= cfg_data;
            end
            if (push)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                flags_reg <= flags_next;
                len_reg   <= len_next;
                cnt_reg   <= cnt_next;
                left_reg  <= left_next;
                tlen_reg  <= tlen_next;
                tleft_reg <= tleft_next;
                pid_reg   <= pid_next;
            end
        end
    end

`include "mqtt_packet_parser_assert.svh"

    `MPP_ASSERT_NXT(a_front_err_discard, push && push_item.err != ERR_OK && !in_end, phase_reg == PH_DISCARD, "Error without buffer end did not enter discard.")
    `MPP_ASSERT_IMP(a_front_err_done, push && push_item.err != ERR_OK, push_item.done, "Error item not marked as packet end.")

endmodule

`default_nettype wire

// ===== src/mpp_queue.sv =====
// ----------------------------------------------------------------------------
// MQTT packet parser queue
// Short first-in first-out buffer of classified items between the front
// and the back, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mpp_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output mpp_pkg::item_t      pop_item
);

    import mpp_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`include "mqtt_packet_parser_assert.svh"

    `MPP_ASSERT_NXT(a_queue_drain, pop && !push, count_reg == $past(count_reg) - QCNT_W'(1), "Queue count did not drop on a pop.")
    `MPP_ASSERT_IMP(a_queue_pop_valid, pop, q_valid, "Pop from an empty queue.")

endmodule

`default_nettype wire

// ===== src/mpp_back.sv =====
// ----------------------------------------------------------------------------
// MQTT packet parser back
// Takes classified items from the queue, works out the payload length of a
// completed packet and presents the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpp_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire mpp_pkg::item_t                      pop_item,
    output logic                                     pop,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [mpp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tlast,
    output logic [mpp_pkg::ROLE_W-1:0]               m_axis_tuser
);

    import mpp_pkg::*;

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg,  tdata_next;
    logic                   tlast_reg;
    logic [ROLE_W-1:0]      tuser_reg;

    logic [17:0]            need;
    logic [LEN_W:0]         diff;
    logic [LEN_W-1:0]       payload;
    logic                   has_payload;

    assign pop = q_valid && (!valid_reg || m_axis_tready);

    always_comb
    begin
        if (pop_item.cmd == CMD_PUBLISH)
        begin
            need = 18'd2 + 18'(pop_item.topic_len)
                 + ((pop_item.flags[2:1] != 2'b00) ? 18'd2 : 18'd0);
        end
        else
        begin
            need = 18'd2;
        end
        diff        = {1'b0, pop_item.rem_len} - (LEN_W + 1)'(need);
        has_payload = (pop_item.cmd == CMD_PUBLISH || pop_item.cmd == CMD_SUBACK)
                      && pop_item.err == ERR_OK && !diff[LEN_W];
        payload     = has_payload ? diff[LEN_W-1:0] : '0;

        tdata_next        = '0;
        tdata_next[7:0]   = pop_item.value;
        if (pop_item.done)
        begin
            tdata_next[11:8]    = pop_item.cmd;
            tdata_next[15:12]   = pop_item.flags;
            tdata_next[43:16]   = pop_item.rem_len;
            tdata_next[59:44]   = pop_item.topic_len;
            tdata_next[75:60]   = pop_item.packet_id;
            tdata_next[103:76]  = payload;
            tdata_next[106:104] = pop_item.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= pop_item.done;
            tuser_reg <= pop_item.role;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;
    assign m_axis_tuser  = tuser_reg;

`include "mqtt_packet_parser_assert.svh"

    `MPP_ASSERT_IMP(a_back_summary_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[OUT_TDATA_W-1:8] == '0, "Summary fields not zero on a byte that does not end a packet.")
    `MPP_ASSERT_NXT(a_back_load, pop, m_axis_tvalid, "Popped item not presented on the output.")

endmodule

`default_nettype wire

// ===== src/mqtt_packet_parser.sv =====
// ----------------------------------------------------------------------------
// MQTT packet parser
// Parses a byte stream of back-to-back MQTT 3.1.1 control packets, tags every
// byte with its role and attaches a packet summary to the closing byte.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle while the queue is not
// full and gives one result per byte. The rate is set by the front parser,
// whose state update for a byte is registered on the byte's transaction; a
// two-entry queue and the output register let the input keep streaming,
// until the queue fills, while a result waits to be taken. Writes to the
// topic length limit take effect at once and are always accepted; they are
// meant to occur while no byte is in flight.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_parser #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // tdata: data_byte[7:0]
    input  wire logic [mpp_pkg::DATA_W-1:0]          s_axis_tdata,
    // tlast: buffer_end
    input  wire logic                                s_axis_tlast,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [mpp_pkg::TOPIC_W-1:0]         cfg_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    // tdata: byte_value[7:0], command[11:8], header_flags[15:12],
    // remaining_length[43:16], topic_length[59:44], packet_id[75:60],
    // payload_length[103:76], error_code[106:104], zero fill[111:107]
    output logic [mpp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // tuser: byte_role[3:0]
    output logic [mpp_pkg::ROLE_W-1:0]               m_axis_tuser,
    // tlast: packet_done
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready
);

    import mpp_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_valid;
    item_t pop_item;

    mpp_front #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    mpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    mpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
